[rtl/bcdcd_pkg.sv]
package bcdcd_pkg;

  localparam int NumDigits  = 4;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;
  localparam int RefreshW   = 8;
  localparam int CountW     = 16;

  typedef logic [3:0]          bcd_t;
  typedef logic [1:0]          scan_pos_t;
  typedef logic [3:0]          anode_t;
  typedef logic [6:0]          seg_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;

  localparam cfg_idx_t CFG_REFRESH_PERIOD = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_COUNT_PERIOD   = cfg_idx_t'(1);

  localparam logic [RefreshW-1:0] REFRESH_PERIOD_RST = 8'd2;
  localparam logic [CountW-1:0]   COUNT_PERIOD_RST   = 16'd50;

  localparam bcd_t   BCD_ZERO   = 4'd0;
  localparam bcd_t   BCD_NINE   = 4'd9;
  localparam anode_t ANODE_DARK = 4'hf;
  localparam seg_t   SEG_BLANK  = 7'h7f;

  typedef struct packed {
    logic                valid;
    cfg_idx_t            index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    anode_t anode;
    seg_t   segment;
  } disp_t;

  typedef struct packed {
    anode_t      anode_drive;
    seg_t        segment_drive;
    logic        point_drive;
    logic [15:0] count_bcd;
  } result_t;

  function automatic seg_t seg_lookup(input bcd_t digit);
    seg_t seg;
    unique case (digit)
      4'd0:    seg = 7'h01;
      4'd1:    seg = 7'h4f;
      4'd2:    seg = 7'h12;
      4'd3:    seg = 7'h06;
      4'd4:    seg = 7'h4c;
      4'd5:    seg = 7'h24;
      4'd6:    seg = 7'h20;
      4'd7:    seg = 7'h0f;
      4'd8:    seg = 7'h00;
      4'd9:    seg = 7'h04;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

  function automatic seg_t alt_lookup(input scan_pos_t pos);
    seg_t seg;
    unique case (pos)
      2'd0:    seg = 7'h06;
      2'd1:    seg = 7'h24;
      2'd2:    seg = 7'h18;
      default: seg = 7'h08;
    endcase
    return seg;
  endfunction

endpackage

[rtl/bcdcd_tick_if.sv]
interface bcdcd_tick_if;
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

[rtl/bcdcd_disp_if.sv]
interface bcdcd_disp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  anode_drive;
  logic [6:0]  segment_drive;
  logic        point_drive;
  logic [15:0] count_bcd;
  modport source (output valid, output anode_drive, output segment_drive,
                  output point_drive, output count_bcd, input ready);
  modport sink   (input valid, input anode_drive, input segment_drive,
                  input point_drive, input count_bcd, output ready);
endinterface

[rtl/bcdcd_cfg_if.sv]
interface bcdcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/bcdcd_digit_cell.sv]
module bcdcd_digit_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic           borrow_in,
  output logic           borrow_out,
  output bcdcd_pkg::bcd_t digit_next
);
  import bcdcd_pkg::*;

  bcd_t digit;

  always_comb begin
    borrow_out = borrow_in && (digit == BCD_ZERO);
    digit_next = digit;
    if (step && borrow_in) begin
      digit_next = (digit == BCD_ZERO) ? BCD_NINE : digit - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit <= BCD_ZERO;
    end else begin
      digit <= digit_next;
    end
  end

endmodule

[rtl/bcdcd_scan.sv]
module bcdcd_scan (
  input  logic              clk,
  input  logic              rst,
  input  bcdcd_pkg::cfg_wr_t cfg_wr,
  input  logic              step,
  input  bcdcd_pkg::bcd_t   digits_next [bcdcd_pkg::NumDigits],
  output logic              count_fire,
  output bcdcd_pkg::disp_t  disp_next
);
  import bcdcd_pkg::*;

  logic [RefreshW-1:0] refresh_period;
  logic [CountW-1:0]   count_period;
  logic [RefreshW-1:0] refresh_ticks, refresh_ticks_next;
  logic [CountW-1:0]   count_ticks, count_ticks_next;
  scan_pos_t           scan_pos, scan_pos_next;
  disp_t               disp;
  logic [CountW:0]     count_sum;
  logic [RefreshW:0]   refresh_sum;
  logic                refresh_fire;
  bcd_t                tens, lit;

  always_comb begin
    count_sum    = {1'b0, count_ticks} + (CountW+1)'(1);
    refresh_sum  = {1'b0, refresh_ticks} + (RefreshW+1)'(1);
    count_fire   = step && (count_sum >= {1'b0, count_period});
    refresh_fire = step && (refresh_sum >= {1'b0, refresh_period});
    tens         = digits_next[1];
    lit          = digits_next[scan_pos];

    count_ticks_next   = count_ticks;
    refresh_ticks_next = refresh_ticks;
    scan_pos_next      = scan_pos;
    disp_next          = disp;
    if (step) begin
      count_ticks_next   = count_fire ? '0 : count_sum[CountW-1:0];
      refresh_ticks_next = refresh_fire ? '0 : refresh_sum[RefreshW-1:0];
    end
    if (refresh_fire) begin
      if (tens == 4'd4 || tens == 4'd5) begin
        disp_next.segment = alt_lookup(scan_pos);
      end else begin
        disp_next.segment = seg_lookup(lit);
      end
      disp_next.anode = ~(anode_t'(1) << scan_pos);
      scan_pos_next   = scan_pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_period <= REFRESH_PERIOD_RST;
      count_period   <= COUNT_PERIOD_RST;
      refresh_ticks  <= '0;
      count_ticks    <= '0;
      scan_pos       <= '0;
      disp.anode     <= ANODE_DARK;
      disp.segment   <= SEG_BLANK;
    end else begin
      if (cfg_wr.valid && cfg_wr.index == CFG_REFRESH_PERIOD) begin
        refresh_period <= cfg_wr.data[RefreshW-1:0];
      end
      if (cfg_wr.valid && cfg_wr.index == CFG_COUNT_PERIOD) begin
        count_period <= cfg_wr.data[CountW-1:0];
      end
      refresh_ticks <= refresh_ticks_next;
      count_ticks   <= count_ticks_next;
      scan_pos      <= scan_pos_next;
      disp          <= disp_next;
    end
  end

endmodule

[rtl/bcd_countdown_7seg_scanner_core.sv]
// Four-digit BCD down counter driving a multiplexed seven-segment display.
// Every accepted ticks transaction yields exactly one display transaction
// holding the anode and segment drives and the packed counter after that
// tick. One transaction is taken per clock while ticks is ready: the counter
// is a row of four digit cells whose borrow ripples units to thousands
// within the cycle, and the prescalers and scan logic finish in the same
// cycle. Results pass through an output register and a skid register, so
// ticks stays ready unless both hold results not yet taken. Configuration
// writes are always ready and take effect on the next clock.
module bcd_countdown_7seg_scanner_core (
  input logic   clk,
  input logic   rst,
  bcdcd_tick_if.sink   ticks,
  bcdcd_disp_if.source display,
  bcdcd_cfg_if.sink    cfg
);
  import bcdcd_pkg::*;

  logic    step, accept, take;
  logic    borrow [NumDigits+1];
  bcd_t    digits_next [NumDigits];
  logic    count_fire;
  disp_t   disp_next;
  cfg_wr_t cfg_wr;
  result_t result, out_data, skid_data;
  logic    out_valid, skid_valid;

  assign cfg.ready    = 1'b1;
  assign cfg_wr.valid = cfg.valid;
  assign cfg_wr.index = cfg.index;
  assign cfg_wr.data  = cfg.data;

  assign ticks.ready = !skid_valid;
  assign accept      = ticks.valid && ticks.ready;
  assign step        = accept && ticks.tick;
  assign take        = out_valid && display.ready;

  assign borrow[0] = count_fire;

  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    bcdcd_digit_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .step       (step),
      .borrow_in  (borrow[i]),
      .borrow_out (borrow[i+1]),
      .digit_next (digits_next[i])
    );
  end

  bcdcd_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_wr),
    .step        (step),
    .digits_next (digits_next),
    .count_fire  (count_fire),
    .disp_next   (disp_next)
  );

  always_comb begin
    result.anode_drive   = disp_next.anode;
    result.segment_drive = disp_next.segment;
    result.point_drive   = 1'b1;
    result.count_bcd     = {digits_next[3], digits_next[2], digits_next[1], digits_next[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (accept) begin
      if (!out_valid || take) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end
  end

  assign display.valid         = out_valid;
  assign display.anode_drive   = out_data.anode_drive;
  assign display.segment_drive = out_data.segment_drive;
  assign display.point_drive   = out_data.point_drive;
  assign display.count_bcd     = out_data.count_bcd;

endmodule

[rtl/bcdcd_chk.sv]
module bcdcd_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  anode_drive,
  input logic        point_drive,
  input logic [15:0] count_bcd
);

  a_point_off: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> point_drive)
    else $error("decimal point driven on");

  a_one_anode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (anode_drive == 4'hf || $onehot(~anode_drive)))
    else $error("more than one digit lit");

  a_bcd_digits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count_bcd[3:0] <= 4'd9 && count_bcd[7:4] <= 4'd9 &&
                   count_bcd[11:8] <= 4'd9 && count_bcd[15:12] <= 4'd9))
    else $error("counter digit out of decimal range");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(count_bcd))
    else $error("stalled result changed");

endmodule

bind bcd_countdown_7seg_scanner_core bcdcd_chk u_bcdcd_chk (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (ticks.ready),
  .out_valid   (display.valid),
  .out_ready   (display.ready),
  .anode_drive (display.anode_drive),
  .point_drive (display.point_drive),
  .count_bcd   (display.count_bcd)
);

[dv/bcd_countdown_7seg_scanner_checker.sv]
module bcd_countdown_7seg_scanner_checker (
  input  logic   clk,
  input  logic   rst,
  bcdcd_tick_if  ticks,
  bcdcd_disp_if  display,
  bcdcd_cfg_if   cfg,
  output int     mismatches,
  output int     pending
);
  import bcdcd_pkg::*;

  localparam seg_t DigitSeg [10] = '{7'h01, 7'h4f, 7'h12, 7'h06, 7'h4c,
                                     7'h24, 7'h20, 7'h0f, 7'h00, 7'h04};
  localparam seg_t TensAltSeg [4] = '{7'h06, 7'h24, 7'h18, 7'h08};

  logic [RefreshW-1:0] refresh_period;
  logic [CountW-1:0]   count_period;
  bcd_t                digits [NumDigits];
  scan_pos_t           scan_pos;
  logic [RefreshW-1:0] refresh_ticks;
  logic [CountW-1:0]   count_ticks;
  anode_t              anode_hold;
  seg_t                seg_hold;
  result_t             expected_display [$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  task automatic count_down();
    bit borrow;
    borrow = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      if (borrow) begin
        if (digits[i] != BCD_ZERO) begin
          digits[i] = digits[i] - 1'b1;
          borrow = 1'b0;
        end else begin
          digits[i] = BCD_NINE;
        end
      end
    end
  endtask

  task automatic scan_digit();
    bcd_t lit;
    lit = digits[scan_pos];
    if (digits[1] == 4'd4 || digits[1] == 4'd5) begin
      seg_hold = TensAltSeg[scan_pos];
    end else if (lit <= BCD_NINE) begin
      seg_hold = DigitSeg[lit];
    end else begin
      seg_hold = SEG_BLANK;
    end
    anode_hold = ~(anode_t'(1) << scan_pos);
    scan_pos = scan_pos + 1'b1;
  endtask

  task automatic advance_tick(input logic tick);
    logic [CountW:0]   count_next;
    logic [RefreshW:0] refresh_next;
    result_t           want;
    if (tick) begin
      count_next = count_ticks + 1'b1;
      refresh_next = refresh_ticks + 1'b1;
      // counter goes first so a scan on the same tick shows the new digits
      if (count_next >= {1'b0, count_period}) begin
        count_ticks = '0;
        count_down();
      end else begin
        count_ticks = count_next[CountW-1:0];
      end
      if (refresh_next >= {1'b0, refresh_period}) begin
        refresh_ticks = '0;
        scan_digit();
      end else begin
        refresh_ticks = refresh_next[RefreshW-1:0];
      end
    end
    want.anode_drive = anode_hold;
    want.segment_drive = seg_hold;
    want.point_drive = 1'b1;
    want.count_bcd = {digits[3], digits[2], digits[1], digits[0]};
    expected_display.push_back(want);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      refresh_period = REFRESH_PERIOD_RST;
      count_period = COUNT_PERIOD_RST;
      for (int i = 0; i < NumDigits; i++) digits[i] = BCD_ZERO;
      scan_pos = '0;
      refresh_ticks = '0;
      count_ticks = '0;
      anode_hold = ANODE_DARK;
      seg_hold = SEG_BLANK;
      expected_display.delete();
    end else begin
      if (display.valid && display.ready) begin
        got.anode_drive = display.anode_drive;
        got.segment_drive = display.segment_drive;
        got.point_drive = display.point_drive;
        got.count_bcd = display.count_bcd;
        if (expected_display.size() == 0) begin
          mismatches++;
          $display("%0t: display transaction with nothing expected, expected none, actual %h",
                   $time, got);
        end else begin
          want = expected_display.pop_front();
          check_field("anode_drive", want.anode_drive, got.anode_drive);
          check_field("segment_drive", want.segment_drive, got.segment_drive);
          check_field("point_drive", want.point_drive, got.point_drive);
          check_field("count_bcd", want.count_bcd, got.count_bcd);
        end
      end
      if (ticks.valid && ticks.ready) advance_tick(ticks.tick);
      // register writes land after any tick taken on the same edge
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_REFRESH_PERIOD: refresh_period = cfg.data[RefreshW-1:0];
          CFG_COUNT_PERIOD:   count_period = cfg.data[CountW-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_display.size();
  end

endmodule

[dv/bcd_countdown_7seg_scanner_core_tb.sv]
module bcd_countdown_7seg_scanner_core_tb;
  import bcdcd_pkg::*;

  localparam cfg_idx_t CFG_SPARE_LO = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_SPARE_HI = cfg_idx_t'(3);
  localparam int NumPhases = 12;
  localparam int PhaseItems = 160;
  localparam int SqueezeAfter = 600;
  localparam int SqueezeCycles = 40;
  localparam int StallLimit = 500;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  int   sent = 0;
  int   stall_cycles = 0;
  bit   calm = 1'b0;
  bit   squeezed = 1'b0;

  bcdcd_tick_if ticks ();
  bcdcd_disp_if display ();
  bcdcd_cfg_if  cfg ();

  bcd_countdown_7seg_scanner_core DUT (
    .clk     (clk),
    .rst     (rst),
    .ticks   (ticks),
    .display (display),
    .cfg     (cfg)
  );

  bcd_countdown_7seg_scanner_checker display_check (
    .clk        (clk),
    .rst        (rst),
    .ticks      (ticks),
    .display    (display),
    .cfg        (cfg),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (ticks.valid && ticks.ready) || (display.valid && display.ready) ||
        (cfg.valid && cfg.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // display side: short random stalls plus one long hold-off
  initial begin
    int burst;
    display.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (!squeezed && sent >= SqueezeAfter) begin
        squeezed = 1'b1;
        display.ready <= 1'b0;
        repeat (SqueezeCycles) @(negedge clk);
        display.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 3);
        display.ready <= 1'b0;
        repeat (burst) @(negedge clk);
        display.ready <= 1'b1;
      end else begin
        display.ready <= 1'b1;
      end
    end
  end

  task automatic send_tick(input logic tick);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      ticks.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    ticks.valid <= 1'b1;
    ticks.tick <= tick;
    @(posedge clk);
    while (!ticks.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    ticks.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value, input bit more);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    if (!more) cfg.valid <= 1'b0;
  endtask

  initial begin
    logic [7:0]  refresh_val;
    logic [15:0] count_val;
    logic        opening [6];
    rst <= 1'b1;
    ticks.valid <= 1'b0;
    ticks.tick <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.index <= CFG_REFRESH_PERIOD;
    cfg.data <= '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // reset periods, idle ticks mixed in
    opening = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    foreach (opening[i]) send_tick(opening[i]);
    drain();

    // unused indexes, then fastest periods through the 0000 wrap
    write_reg(CFG_SPARE_LO, 16'hffff, 1'b1);
    write_reg(CFG_SPARE_HI, 16'h0000, 1'b1);
    write_reg(CFG_REFRESH_PERIOD, 16'h0001, 1'b1);
    write_reg(CFG_COUNT_PERIOD, 16'h0001, 1'b0);
    repeat (19) send_tick(1'b1);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        0: begin refresh_val = 8'd1;   count_val = 16'd1;     end
        1: begin refresh_val = 8'd255; count_val = 16'd1;     end
        2: begin refresh_val = 8'd0;   count_val = 16'd0;     end
        3: begin refresh_val = 8'd3;   count_val = 16'hffff;  end
        4: begin refresh_val = 8'd200; count_val = 16'd300;   end
        5: begin refresh_val = 8'd5;   count_val = 16'd7;     end
        default: begin
          refresh_val = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(1, 4));
          count_val = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(1, 3));
          if ($urandom_range(0, 2) == 0)
            write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                      16'($urandom), 1'b1);
        end
      endcase
      write_reg(CFG_REFRESH_PERIOD, {8'($urandom), refresh_val}, 1'b1);
      write_reg(CFG_COUNT_PERIOD, count_val, 1'b0);
      if (ph == NumPhases - 1) calm = 1'b1;
      repeat (PhaseItems) send_tick($urandom_range(0, 4) != 0);
    end

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
